### rtl/epx_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// epx_pkg
// Shared types and constants for the EPX 2x pixel upscaler.
// ---------------------------------------------------------------------------
package epx_pkg;

    // Default maximum frame sizes; the width also sets the line-store depth.
    localparam int DEF_MAX_WIDTH  = 512;
    localparam int DEF_MAX_HEIGHT = 512;

    // Fixed field widths of the payload.
    localparam int PIXEL_BITS = 8;
    localparam int SRC_W      = 9;
    localparam int CFG_W      = 10;

    // Configuration port.
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;
    localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = CFG_W'(320);
    localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = CFG_W'(200);

    // Request opcodes.
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    typedef struct packed {
        logic                  op;
        logic [PIXEL_BITS-1:0] pixel_in;
    } epx_in_t;

    typedef struct packed {
        logic [PIXEL_BITS-1:0] top_left;
        logic [PIXEL_BITS-1:0] top_right;
        logic [PIXEL_BITS-1:0] bottom_left;
        logic [PIXEL_BITS-1:0] bottom_right;
        logic [SRC_W-1:0]      src_col;
        logic [SRC_W-1:0]      src_row;
        logic                  frame_end;
    } epx_out_t;

    // Per-block information handed from the controller to the kernel.
    // A fetch entry only reloads the left neighbor and produces no block.
    typedef struct packed {
        logic [SRC_W-1:0]      col;
        logic [SRC_W-1:0]      row;
        logic                  a_is_p;
        logic                  b_is_p;
        logic                  c_is_p;
        logic                  drain;
        logic                  frame_end;
        logic                  fetch;
        logic                  sel;
        logic [PIXEL_BITS-1:0] pix;
    } epx_issue_t;

endpackage : epx_pkg
`default_nettype wire

### rtl/epx_2x_pixel_upscale_top.sv
// A block passes the read stage and the output register after the accepting
// edge of the request that completes it (the pixel below or a drain request).
// Throughput: one request per cycle unless the output stalls; after a mid-frame
// size change a request may wait while its left neighbor is fetched from a store.
// Reset: counters and handshake state clear at once; the line stores are not
// cleared and need no clearing pass.
`default_nettype none
// ---------------------------------------------------------------------------
// epx_2x_pixel_upscale_top
// EPX (Scale2x) 2x upscaler for an indexed pixel stream with two line stores.
// ---------------------------------------------------------------------------
module epx_2x_pixel_upscale_top import epx_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire epx_in_t               s_data,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output epx_out_t                   m_data
);

    localparam int XW = $clog2(MAX_WIDTH);

    logic [CFG_W-1:0] frame_width_reg, frame_width_next;
    logic [CFG_W-1:0] frame_height_reg, frame_height_next;
    logic             cfg_wr;

    logic                  take_ok, rd_en, wr_en, wr_sel, iss_valid;
    logic [XW-1:0]         rd_addr0, rd_addr1;
    logic [PIXEL_BITS-1:0] wr_data;
    logic [PIXEL_BITS-1:0] rd_a0, rd_a1, rd_b0, rd_b1;
    epx_issue_t            iss;

    // Configuration registers.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb begin
        frame_width_next  = frame_width_reg;
        frame_height_next = frame_height_reg;
        if (cfg_wr) begin
            case (paddr[2])
                REG_FRAME_WIDTH:  frame_width_next  = pwdata[CFG_W-1:0];
                REG_FRAME_HEIGHT: frame_height_next = pwdata[CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_FRAME_WIDTH:  prdata = APB_DATA_W'(frame_width_reg);
            REG_FRAME_HEIGHT: prdata = APB_DATA_W'(frame_height_reg);
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= FRAME_WIDTH_RST;
            frame_height_reg <= FRAME_HEIGHT_RST;
        end else begin
            frame_width_reg  <= frame_width_next;
            frame_height_reg <= frame_height_next;
        end
    end

    // Raster control and line-store addressing.
    epx_ctrl #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_data       (s_data),
        .s_ready      (s_ready),
        .take_ok      (take_ok),
        .frame_width  (frame_width_reg),
        .frame_height (frame_height_reg),
        .rd_en        (rd_en),
        .rd_addr0     (rd_addr0),
        .rd_addr1     (rd_addr1),
        .wr_en        (wr_en),
        .wr_sel       (wr_sel),
        .wr_data      (wr_data),
        .iss_valid    (iss_valid),
        .iss          (iss)
    );

    // Two line stores; the select bit names the one taking the current row.
    epx_ram #(
        .WIDTH (PIXEL_BITS),
        .DEPTH (MAX_WIDTH)
    ) u_store_a (
        .aclk   (aclk),
        .we     (wr_en && !wr_sel),
        .waddr  (rd_addr0),
        .wdata  (wr_data),
        .re     (rd_en),
        .raddr0 (rd_addr0),
        .raddr1 (rd_addr1),
        .rdata0 (rd_a0),
        .rdata1 (rd_a1)
    );

    epx_ram #(
        .WIDTH (PIXEL_BITS),
        .DEPTH (MAX_WIDTH)
    ) u_store_b (
        .aclk   (aclk),
        .we     (wr_en && wr_sel),
        .waddr  (rd_addr0),
        .wdata  (wr_data),
        .re     (rd_en),
        .raddr0 (rd_addr0),
        .raddr1 (rd_addr1),
        .rdata0 (rd_b0),
        .rdata1 (rd_b1)
    );

    // Scale2x rules and output register.
    epx_kernel u_kernel (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .iss_valid (iss_valid),
        .iss       (iss),
        .rd_a0     (rd_a0),
        .rd_a1     (rd_a1),
        .rd_b0     (rd_b0),
        .rd_b1     (rd_b1),
        .take_ok   (take_ok),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule : epx_2x_pixel_upscale_top
`default_nettype wire

### rtl/epx_ram.sv
`default_nettype none
// ---------------------------------------------------------------------------
// epx_ram
// Generic RAM with one write port and two registered read ports.
// A read of the address being written returns the old contents.
// ---------------------------------------------------------------------------
module epx_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr0,
    input  wire logic [$clog2(DEPTH)-1:0] raddr1,
    output logic      [WIDTH-1:0]         rdata0,
    output logic      [WIDTH-1:0]         rdata1
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd0_reg;
    logic [WIDTH-1:0] rd1_reg;

    // Write port and both read ports.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rd0_reg <= mem_reg[raddr0];
            rd1_reg <= mem_reg[raddr1];
        end
    end

    assign rdata0 = rd0_reg;
    assign rdata1 = rd1_reg;

endmodule : epx_ram
`default_nettype wire

### rtl/epx_ctrl.sv
`default_nettype none
// ---------------------------------------------------------------------------
// epx_ctrl
// Raster counters, line-store addressing and drain sequencing.
// Issues the line-store reads and writes for each request and hands the
// border information of each produced block to the kernel.
// ---------------------------------------------------------------------------
module epx_ctrl import epx_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_valid,
    input  wire epx_in_t                      s_data,
    output logic                              s_ready,
    input  wire logic                         take_ok,
    input  wire logic [CFG_W-1:0]             frame_width,
    input  wire logic [CFG_W-1:0]             frame_height,
    output logic                              rd_en,
    output logic [$clog2(MAX_WIDTH)-1:0]      rd_addr0,
    output logic [$clog2(MAX_WIDTH)-1:0]      rd_addr1,
    output logic                              wr_en,
    output logic                              wr_sel,
    output logic [PIXEL_BITS-1:0]             wr_data,
    output logic                              iss_valid,
    output epx_issue_t                        iss
);

    localparam int XW = $clog2(MAX_WIDTH);
    localparam int YW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

    logic [XW-1:0] col_reg, col_next;
    logic [YW-1:0] row_reg, row_next;
    logic          sel_reg, sel_next;
    logic          drain_reg, drain_next;
    logic [XW-1:0] lastx_reg, lastx_next;
    logic          lastok_reg, lastok_next;

    logic [31:0]   fw32, fh32;
    logic [XW-1:0] col_last;
    logic [YW-1:0] row_last;
    logic [XW-1:0] x;
    logic [YW-1:0] r;
    logic          accept, drain_step, pixel_step, x_is_last, r_is_last;
    logic          will_issue, left_known, need_fetch, fetch;

    // Clamp the configured sizes to 1..MAX and form the last column and row.
    always_comb begin
        fw32 = 32'(frame_width);
        fh32 = 32'(frame_height);
        if (fw32 == 32'd0) begin
            col_last = '0;
        end else if (fw32 > 32'(MAX_WIDTH)) begin
            col_last = XW'(MAX_WIDTH - 1);
        end else begin
            col_last = XW'(fw32 - 32'd1);
        end
        if (fh32 == 32'd0) begin
            row_last = '0;
        end else if (fh32 > 32'(MAX_HEIGHT)) begin
            row_last = YW'(MAX_HEIGHT - 1);
        end else begin
            row_last = YW'(fh32 - 32'd1);
        end
    end

    // Counters are read saturated to the current frame size.
    assign x = (col_reg > col_last) ? col_last : col_reg;
    assign r = (row_reg > row_last) ? row_last : row_reg;

    assign x_is_last  = (x == col_last);
    assign r_is_last  = (r == row_last);
    assign drain_step = drain_reg && (s_data.op == OP_DRAIN);
    assign pixel_step = !drain_reg && (s_data.op == OP_PIXEL);
    assign will_issue = drain_step || (pixel_step && (r != '0));

    // The kernel keeps the previous block's center as the left neighbor.
    // When the previous block was not at x-1, which only happens after a
    // size change in mid-frame, a separate fetch entry reads the left pixel.
    assign left_known = (x == '0) || (lastok_reg && (x == lastx_reg + XW'(1)));
    assign need_fetch = s_valid && will_issue && !left_known;
    assign fetch      = need_fetch && take_ok;
    assign s_ready    = take_ok && !need_fetch;
    assign accept     = s_valid && s_ready;

    // Line-store access: the row above at x and x+1, and at x the older row still in the store taking the current row.
    assign rd_en    = accept || fetch;
    assign rd_addr0 = need_fetch ? x - XW'(1) : x;
    assign rd_addr1 = x + XW'(1);
    assign wr_en    = accept && pixel_step;
    assign wr_sel   = sel_reg;
    assign wr_data  = s_data.pixel_in;

    // Block information for the kernel.
    always_comb begin
        iss_valid     = (accept && will_issue) || fetch;
        iss.col       = SRC_W'(x);
        iss.row       = drain_reg ? SRC_W'(r) : SRC_W'(r - YW'(1));
        iss.a_is_p    = drain_reg ? (r == '0) : (r == YW'(1));
        iss.b_is_p    = x_is_last;
        iss.c_is_p    = (x == '0);
        iss.drain     = drain_reg;
        iss.frame_end = drain_reg && x_is_last;
        iss.fetch     = need_fetch;
        iss.sel       = sel_reg;
        iss.pix       = s_data.pixel_in;
    end

    // Track the column of the last block whose center the kernel holds.
    always_comb begin
        lastx_next  = lastx_reg;
        lastok_next = lastok_reg;
        if (fetch) begin
            lastx_next  = x - XW'(1);
            lastok_next = 1'b1;
        end else if (accept && (drain_step || pixel_step)) begin
            lastx_next  = x;
            lastok_next = will_issue;
        end
    end

    // Raster and drain sequencing.
    always_comb begin
        col_next   = col_reg;
        row_next   = row_reg;
        sel_next   = sel_reg;
        drain_next = drain_reg;
        if (accept && drain_step) begin
            if (x_is_last) begin
                col_next   = '0;
                row_next   = '0;
                sel_next   = 1'b0;
                drain_next = 1'b0;
            end else begin
                col_next = x + XW'(1);
                row_next = r;
            end
        end else if (accept && pixel_step) begin
            if (x_is_last) begin
                col_next = '0;
                sel_next = !sel_reg;
                if (r_is_last) begin
                    drain_next = 1'b1;
                    row_next   = r;
                end else begin
                    row_next = r + YW'(1);
                end
            end else begin
                col_next = x + XW'(1);
                row_next = r;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg    <= '0;
            row_reg    <= '0;
            sel_reg    <= 1'b0;
            drain_reg  <= 1'b0;
            lastx_reg  <= '0;
            lastok_reg <= 1'b0;
        end else begin
            col_reg    <= col_next;
            row_reg    <= row_next;
            sel_reg    <= sel_next;
            drain_reg  <= drain_next;
            lastx_reg  <= lastx_next;
            lastok_reg <= lastok_next;
        end
    end

endmodule : epx_ctrl
`default_nettype wire

### rtl/epx_kernel.sv
`default_nettype none
// ---------------------------------------------------------------------------
// epx_kernel
// Applies the Scale2x rules to the line-store read data and holds the
// finished block in the output register.
// ---------------------------------------------------------------------------
module epx_kernel import epx_pkg::*; (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  iss_valid,
    input  wire epx_issue_t            iss,
    input  wire logic [PIXEL_BITS-1:0] rd_a0,
    input  wire logic [PIXEL_BITS-1:0] rd_a1,
    input  wire logic [PIXEL_BITS-1:0] rd_b0,
    input  wire logic [PIXEL_BITS-1:0] rd_b1,
    output logic                       take_ok,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output epx_out_t                   m_data
);

    logic       s2_valid_reg, s2_valid_next;
    epx_issue_t s2_info_reg;
    logic [PIXEL_BITS-1:0] last_p_reg;
    logic       m_valid_reg, m_valid_next;
    epx_out_t   m_data_reg, m_data_next;

    logic out_load, s2_adv;
    logic [PIXEL_BITS-1:0] prev0, prev1, cur0;
    logic [PIXEL_BITS-1:0] p, a, b, c, d;

    // Handshake between the read stage and the output register.
    // A fetch entry leaves the read stage at once without an output block.
    assign out_load = !m_valid_reg || m_ready;
    assign s2_adv   = s2_valid_reg && (s2_info_reg.fetch || out_load);
    assign take_ok  = !s2_valid_reg || s2_adv;

    always_comb begin
        s2_valid_next = s2_valid_reg;
        if (iss_valid) begin
            s2_valid_next = 1'b1;
        end else if (s2_adv) begin
            s2_valid_next = 1'b0;
        end
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = s2_valid_reg && !s2_info_reg.fetch;
        end
    end

    // Pick the row above and the row before it from the two stores.
    assign prev0 = s2_info_reg.sel ? rd_a0 : rd_b0;
    assign prev1 = s2_info_reg.sel ? rd_a1 : rd_b1;
    assign cur0  = s2_info_reg.sel ? rd_b0 : rd_a0;

    // Neighbors, with the border replaced by the center pixel.
    assign p = prev0;
    assign a = s2_info_reg.a_is_p ? p : cur0;
    assign b = s2_info_reg.b_is_p ? p : prev1;
    assign c = s2_info_reg.c_is_p ? p : last_p_reg;
    assign d = s2_info_reg.drain  ? p : s2_info_reg.pix;

    // Scale2x rules.
    always_comb begin
        m_data_next.top_left     = (c == a && c != d && a != b) ? a : p;
        m_data_next.top_right    = (a == b && a != c && b != d) ? b : p;
        m_data_next.bottom_left  = (d == c && d != b && c != a) ? c : p;
        m_data_next.bottom_right = (b == d && b != a && d != c) ? d : p;
        m_data_next.src_col      = s2_info_reg.col;
        m_data_next.src_row      = s2_info_reg.row;
        m_data_next.frame_end    = s2_info_reg.frame_end;
    end

    // Payload registers; the center pixel becomes the next block's left.
    always_ff @(posedge aclk) begin
        if (iss_valid) begin
            s2_info_reg <= iss;
        end
        if (s2_adv) begin
            last_p_reg <= p;
        end
        if (s2_adv && !s2_info_reg.fetch) begin
            m_data_reg <= m_data_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            s2_valid_reg <= s2_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule : epx_kernel
`default_nettype wire

### test/epx_2x_pixel_upscale_top_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// epx_2x_pixel_upscale_top_tb
// Self-checking bench for the EPX 2x upscaler. Pixel and drain requests are
// streamed through the input channel under random stalls. A line-store
// predictor builds the expected 2x2 blocks at acceptance time. Every block
// on the result channel is compared with the oldest prediction. Frame sizes
// are changed through the APB port only while the block is idle.
// ---------------------------------------------------------------------------
module epx_2x_pixel_upscale_top_tb;
    import epx_pkg::*;

    localparam int MAXW         = DEF_MAX_WIDTH;
    localparam int MAXH         = DEF_MAX_HEIGHT;
    localparam int SETTLE       = 8;
    localparam int STALL_LIMIT  = 5000;
    localparam int RANDOM_ITEMS = 490;
    // Directed 3x3 frame, raster order, with both pixel extremes.
    localparam logic [71:0] TILE = 72'h00_00_FF_00_5A_FF_A5_FF_FF;

    logic                  aclk    = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [APB_ADDR_W-1:0] paddr   = '0;
    logic [APB_DATA_W-1:0] pwdata  = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    epx_in_t               s_data  = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    epx_out_t              m_data;

    // Requests waiting to be driven and blocks waiting to be seen.
    epx_in_t  req_queue[$];
    epx_out_t blocks_due[$];

    // Predictor state and configuration.
    logic [PIXEL_BITS-1:0] line_mem [2][MAXW];
    int                    col_cnt   = 0;
    int                    row_cnt   = 0;
    logic                  store_sel = 1'b0;
    logic                  draining  = 1'b0;
    logic [CFG_W-1:0]      cfg_width  = FRAME_WIDTH_RST;
    logic [CFG_W-1:0]      cfg_height = FRAME_HEIGHT_RST;

    // Bookkeeping.
    int   pushed_cnt     = 0;
    int   accepted_cnt   = 0;
    int   blocks_checked = 0;
    int   bad_blocks     = 0;
    int   frames_sent    = 0;
    int   quiet_cycles   = 0;
    int   idle_pct       = 36;
    logic req_taken      = 1'b0;

    epx_2x_pixel_upscale_top dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // 100 MHz clock.
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Sizes outside the legal range are used clamped.
    function automatic int eff_size(input logic [CFG_W-1:0] v, input int hi);
        if (v == 0) begin
            return 1;
        end
        return (int'(v) > hi) ? hi : int'(v);
    endfunction

    // Scale2x rules for one source pixel and its four neighbors.
    function automatic epx_out_t epx_block(input logic [PIXEL_BITS-1:0] p, a, b, c, d,
                                           input int x, input int y, input logic last);
        epx_out_t blk;
        blk.top_left     = (c == a && c != d && a != b) ? a : p;
        blk.top_right    = (a == b && a != c && b != d) ? b : p;
        blk.bottom_left  = (d == c && d != b && c != a) ? c : p;
        blk.bottom_right = (b == d && b != a && d != c) ? d : p;
        blk.src_col      = SRC_W'(x);
        blk.src_row      = SRC_W'(y);
        blk.frame_end    = last;
        return blk;
    endfunction

    // Advance the line-store predictor by one accepted request.
    task automatic scale2x_step(input epx_in_t req);
        int                    w, h, x, r;
        logic                  cur, prv;
        logic [PIXEL_BITS-1:0] p, a, b, c;
        w   = eff_size(cfg_width, MAXW);
        h   = eff_size(cfg_height, MAXH);
        x   = (col_cnt < w) ? col_cnt : w - 1;
        r   = (row_cnt < h) ? row_cnt : h - 1;
        cur = store_sel;
        prv = ~store_sel;
        if (draining) begin
            // The last row is flushed with the pixel itself as its lower neighbor.
            if (req.op == OP_DRAIN) begin
                p = line_mem[prv][x];
                a = (r > 0) ? line_mem[cur][x] : p;
                b = (x + 1 < w) ? line_mem[prv][x + 1] : p;
                c = (x > 0) ? line_mem[prv][x - 1] : p;
                blocks_due.push_back(epx_block(p, a, b, c, p, x, r, x + 1 >= w));
                if (x + 1 >= w) begin
                    col_cnt   = 0;
                    row_cnt   = 0;
                    store_sel = 1'b0;
                    draining  = 1'b0;
                end else begin
                    col_cnt = x + 1;
                    row_cnt = r;
                end
            end
        end else if (req.op == OP_PIXEL) begin
            // A pixel completes the block directly above it.
            if (r >= 1) begin
                p = line_mem[prv][x];
                a = (r - 1 > 0) ? line_mem[cur][x] : p;
                b = (x + 1 < w) ? line_mem[prv][x + 1] : p;
                c = (x > 0) ? line_mem[prv][x - 1] : p;
                blocks_due.push_back(epx_block(p, a, b, c, req.pixel_in, x, r - 1, 1'b0));
            end
            line_mem[cur][x] = req.pixel_in;
            if (x + 1 >= w) begin
                col_cnt   = 0;
                store_sel = ~store_sel;
                if (r + 1 >= h) begin
                    draining = 1'b1;
                    row_cnt  = r;
                end else begin
                    row_cnt = r + 1;
                end
            end else begin
                col_cnt = x + 1;
                row_cnt = r;
            end
        end
    endtask

    task automatic push_req(input logic op, input logic [PIXEL_BITS-1:0] pix);
        epx_in_t req;
        req.op       = op;
        req.pixel_in = pix;
        req_queue.push_back(req);
        pushed_cnt++;
    endtask

    // One full frame plus its drain, with optional ignored requests mixed in.
    task automatic queue_frame(input int w, input int h, input int colors, input int noise_pct);
        logic [PIXEL_BITS-1:0] pal [4];
        int                    i;
        for (i = 0; i < 4; i++) begin
            pal[i] = PIXEL_BITS'($urandom);
        end
        for (i = 0; i < w * h; i++) begin
            if ($urandom_range(99) < noise_pct) begin
                push_req(OP_DRAIN, PIXEL_BITS'($urandom));
            end
            if (colors == 0) begin
                push_req(OP_PIXEL, PIXEL_BITS'($urandom));
            end else begin
                push_req(OP_PIXEL, pal[$urandom_range(colors - 1)]);
            end
        end
        for (i = 0; i < w; i++) begin
            if ($urandom_range(99) < noise_pct) begin
                push_req(OP_PIXEL, PIXEL_BITS'($urandom));
            end
            push_req(OP_DRAIN, PIXEL_BITS'($urandom));
        end
        frames_sent++;
    endtask

    // Wait until every request is taken and every block has arrived.
    task automatic wait_quiet();
        while (accepted_cnt != pushed_cnt || blocks_due.size() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE) @(posedge aclk);
    endtask

    // APB write: setup cycle, then access cycle until pready.
    task automatic write_reg(input logic idx, input logic [APB_DATA_W-1:0] value);
        @(negedge aclk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = APB_ADDR_W'({idx, 2'b00});
        pwdata  = value;
        @(negedge aclk);
        penable = 1'b1;
        @(posedge aclk);
        while (!pready) begin
            @(posedge aclk);
        end
        if (idx == REG_FRAME_WIDTH) begin
            cfg_width = value[CFG_W-1:0];
        end else begin
            cfg_height = value[CFG_W-1:0];
        end
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // Driver: offer the next request at the falling edge, hold it until taken.
    always @(negedge aclk) begin
        if (aresetn) begin
            if (!s_valid || req_taken) begin
                if (req_queue.size() != 0 && $urandom_range(99) >= idle_pct) begin
                    s_data  <= req_queue.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
            req_taken = 1'b0;
            m_ready <= ($urandom_range(99) >= idle_pct);
        end
    end

    // Monitor: check blocks, predict accepted requests, watch for stalls.
    always @(posedge aclk) begin
        if (aresetn) begin
            quiet_cycles++;
            if (m_valid && m_ready) begin
                quiet_cycles = 0;
                if (blocks_due.size() == 0) begin
                    bad_blocks++;
                    if (bad_blocks <= 10) begin
                        $display("unexpected block: col=%0d row=%0d end=%b",
                                 m_data.src_col, m_data.src_row, m_data.frame_end);
                    end
                end else begin
                    if (m_data.top_left     !== blocks_due[0].top_left     ||
                        m_data.top_right    !== blocks_due[0].top_right    ||
                        m_data.bottom_left  !== blocks_due[0].bottom_left  ||
                        m_data.bottom_right !== blocks_due[0].bottom_right ||
                        m_data.src_col      !== blocks_due[0].src_col      ||
                        m_data.src_row      !== blocks_due[0].src_row      ||
                        m_data.frame_end    !== blocks_due[0].frame_end) begin
                        bad_blocks++;
                        if (bad_blocks <= 10) begin
                            $display("mismatch: expected %h %h %h %h col=%0d row=%0d end=%b",
                                     blocks_due[0].top_left, blocks_due[0].top_right,
                                     blocks_due[0].bottom_left, blocks_due[0].bottom_right,
                                     blocks_due[0].src_col, blocks_due[0].src_row,
                                     blocks_due[0].frame_end);
                            $display("          got      %h %h %h %h col=%0d row=%0d end=%b",
                                     m_data.top_left, m_data.top_right, m_data.bottom_left,
                                     m_data.bottom_right, m_data.src_col, m_data.src_row,
                                     m_data.frame_end);
                        end
                    end
                    void'(blocks_due.pop_front());
                    blocks_checked++;
                end
            end
            if (s_valid && s_ready) begin
                quiet_cycles = 0;
                scale2x_step(s_data);
                accepted_cnt++;
                req_taken = 1'b1;
            end
            if (psel && penable && pready) begin
                quiet_cycles = 0;
            end
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    // Stimulus sequence.
    initial begin
        int i, n, w, h, x, r, remaining, random_items;
        int raw_w, raw_h;

        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed 3x3 frame with an early drain, then a pixel during the drain.
        write_reg(REG_FRAME_WIDTH, 3);
        write_reg(REG_FRAME_HEIGHT, 3);
        push_req(OP_DRAIN, 8'hFF);
        for (i = 0; i < 9; i++) begin
            if (i == 4) begin
                push_req(OP_DRAIN, 8'h00);
            end
            push_req(OP_PIXEL, TILE[8 * (8 - i) +: 8]);
        end
        push_req(OP_DRAIN, 8'h00);
        push_req(OP_PIXEL, 8'hFF);
        push_req(OP_DRAIN, 8'hFF);
        push_req(OP_DRAIN, 8'h00);
        frames_sent++;
        wait_quiet();

        // Single-row frame: nothing comes out before the drain.
        write_reg(REG_FRAME_WIDTH, 4);
        write_reg(REG_FRAME_HEIGHT, 1);
        push_req(OP_PIXEL, 8'h00);
        push_req(OP_PIXEL, 8'hFF);
        push_req(OP_PIXEL, 8'hFF);
        push_req(OP_PIXEL, 8'h3C);
        for (i = 0; i < 4; i++) begin
            push_req(OP_DRAIN, 8'h00);
        end
        frames_sent++;
        wait_quiet();

        // Sender pauses mid-frame, then the frame shrinks before it resumes.
        write_reg(REG_FRAME_WIDTH, 6);
        write_reg(REG_FRAME_HEIGHT, 5);
        for (i = 0; i < 15; i++) begin
            push_req(OP_PIXEL, (i % 3 == 0) ? 8'h11 : 8'h22);
        end
        wait_quiet();
        write_reg(REG_FRAME_WIDTH, 3);
        write_reg(REG_FRAME_HEIGHT, 3);
        w = eff_size(cfg_width, MAXW);
        h = eff_size(cfg_height, MAXH);
        x = (col_cnt < w) ? col_cnt : w - 1;
        r = (row_cnt < h) ? row_cnt : h - 1;
        remaining = draining ? 0 : (h - 1 - r) * w + (w - x);
        for (i = 0; i < remaining; i++) begin
            push_req(OP_PIXEL, $urandom_range(1) ? 8'h11 : 8'h22);
        end
        for (i = 0; i < w; i++) begin
            push_req(OP_DRAIN, 8'h00);
        end
        frames_sent++;

        // Random frames: small sizes, small palettes, a little ignored noise.
        random_items = 0;
        n = 0;
        while (random_items < RANDOM_ITEMS) begin
            if (n == 0 || $urandom_range(1) == 1) begin
                wait_quiet();
                raw_w = $urandom_range(1, 8);
                raw_h = $urandom_range(1, 6);
                if ($urandom_range(9) == 0) begin
                    raw_w = 0;
                end
                if ($urandom_range(9) == 0) begin
                    raw_h = 0;
                end
                write_reg(REG_FRAME_WIDTH, raw_w);
                write_reg(REG_FRAME_HEIGHT, raw_h);
            end
            idle_pct = (n >= 5 && n < 10) ? 0 : 36;
            w = eff_size(cfg_width, MAXW);
            h = eff_size(cfg_height, MAXH);
            queue_frame(w, h, $urandom_range(4), 4);
            random_items += w * h + w;
            n++;
        end
        wait_quiet();
        idle_pct = 36;

        // Width written as zero and height with junk upper bits.
        write_reg(REG_FRAME_WIDTH, 32'hFFFF_FC00);
        write_reg(REG_FRAME_HEIGHT, 32'hFFFF_FC03);
        queue_frame(eff_size(cfg_width, MAXW), eff_size(cfg_height, MAXH), 2, 2);
        wait_quiet();

        $display("summary: %0d frames, %0d requests accepted, %0d blocks checked",
                 frames_sent, accepted_cnt, blocks_checked);
        $display("summary: %0d bad blocks", bad_blocks);
        if (bad_blocks == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
